FILE: rtl/core/mono_sample_ring_hold_last_top_assert.svh
// Assertion macros shared by the ring block.
// Each macro checks on the rising edge of clk and is disabled while arst_n is low.
`ifndef MONO_SAMPLE_RING_HOLD_LAST_TOP_ASSERT_SVH
`define MONO_SAMPLE_RING_HOLD_LAST_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define MSRHL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MSRHL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MSRHL_ASSERT_NOW(lbl, ante, cons, msg)
`define MSRHL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/core/msrhl_pkg.sv
package msrhl_pkg;

	localparam int unsigned RING_DEPTH_DEF = 1024;
	localparam int unsigned SAMPLE_W       = 8;
	localparam int unsigned HELD_W         = 16;
	localparam int unsigned WORD_W         = 32;
	localparam int unsigned FILL_LEVEL_W   = 11;
	localparam int unsigned UNDERRUN_W     = 32;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_PULL = 1'b1
	} action_t;

	// request beat
	typedef struct packed {
		action_t                    action;
		logic signed [SAMPLE_W-1:0] sample_in;
	} req_t;

	// response beat
	typedef struct packed {
		logic [WORD_W-1:0]       stereo_word;
		logic                    accepted;
		logic [FILL_LEVEL_W-1:0] fill_level;
		logic [UNDERRUN_W-1:0]   underrun_count;
	} rsp_t;

endpackage

FILE: rtl/core/msrhl_ring_mem.sv
module msrhl_ring_mem
	import msrhl_pkg::*;
#(
	parameter int unsigned DEPTH = RING_DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [SAMPLE_W-1:0] wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic [SAMPLE_W-1:0] rd_data
);

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/mono_sample_ring_hold_last_top.sv
// Mono sample ring with hold-last-sample on underrun.
// Request channel (req_valid / req_stall / req): each beat is a push of one
// signed 8-bit sample or a pull of one stereo frame. Response channel
// (rsp_valid / rsp_stall / rsp): exactly one beat per request, in order.
// A push stores the sample unless the ring is full (then it is dropped).
// A pull pops the oldest sample, widens it by << 8 and holds it; on an empty
// ring the held sample repeats and the underrun counter increments.
// Push and underrun pull responses are registered straight from the accepted
// request; a popping pull's response is registered from the ring RAM read data
// after the pop_s1 stage, since the RAM read port is registered.
// Throughput: one beat per cycle for pushes and underrun pulls while rsp_stall
// is low; a popping pull holds off requests (pop_s1) during its RAM read.
// Reset clears pointers, fill count, held sample and underrun counter; RAM
// contents are left as they are and need no clearing pass.
// While the response register holds a stalled beat, requests are stalled too;
// a new request is taken in the same cycle the held beat drains.
module mono_sample_ring_hold_last_top
	import msrhl_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned AW     = $clog2(RING_DEPTH);
	localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);

	logic [AW-1:0]         wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0]     fill_q, fill_nxt;
	logic [HELD_W-1:0]     held_q;
	logic [UNDERRUN_W-1:0] under_q, under_nxt;
	logic                  pop_s1;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic req_fire, rsp_fire, is_pull, empty, full;
	logic do_push, do_pop, do_under;
	logic [SAMPLE_W-1:0] rd_data;

	// handshakes
	assign rsp_fire  = rsp_valid_q && !rsp_stall;
	assign req_stall = pop_s1 || (rsp_valid_q && rsp_stall);
	assign req_fire  = req_valid && !req_stall;

	// decode
	assign is_pull  = (req.action == ACT_PULL);
	assign empty    = (fill_q == '0);
	assign full     = (fill_q == FILL_W'(RING_DEPTH));
	assign do_push  = req_fire && !is_pull && !full;
	assign do_pop   = req_fire && is_pull && !empty;
	assign do_under = req_fire && is_pull && empty;

	// next fill level and underrun count
	always_comb begin
		fill_nxt  = fill_q;
		under_nxt = under_q;
		if (do_push) begin
			fill_nxt = fill_q + FILL_W'(1);
		end else if (do_pop) begin
			fill_nxt = fill_q - FILL_W'(1);
		end
		if (do_under) begin
			under_nxt = under_q + UNDERRUN_W'(1);
		end
	end

	msrhl_ring_mem #(
		.DEPTH (RING_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (do_push),
		.wr_addr (wr_ptr_q),
		.wr_data (req.sample_in),
		.rd_en   (do_pop),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			under_q  <= '0;
			held_q   <= '0;
			pop_s1   <= 1'b0;
		end else begin
			fill_q  <= fill_nxt;
			under_q <= under_nxt;
			pop_s1  <= do_pop;
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (pop_s1) begin
				held_q <= {rd_data, SAMPLE_W'(0)};
			end
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((req_fire && !do_pop) || pop_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_fire) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (pop_s1) begin
			rsp_q.stereo_word    <= {rd_data, SAMPLE_W'(0), rd_data, SAMPLE_W'(0)};
			rsp_q.accepted       <= 1'b1;
			rsp_q.fill_level     <= FILL_LEVEL_W'(fill_q);
			rsp_q.underrun_count <= under_q;
		end else if (req_fire && !do_pop) begin
			rsp_q.stereo_word    <= is_pull ? {held_q, held_q} : '0;
			rsp_q.accepted       <= do_push;
			rsp_q.fill_level     <= FILL_LEVEL_W'(fill_nxt);
			rsp_q.underrun_count <= under_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "mono_sample_ring_hold_last_top_assert.svh"

	`MSRHL_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_W'(RING_DEPTH), "fill above depth")
	`MSRHL_ASSERT_NOW(a_s1_slot_free, pop_s1, !rsp_valid_q, "pop data with busy response slot")
	`MSRHL_ASSERT_NEXT(a_pop_lands, do_pop, pop_s1 && !rsp_valid_q, "pop read not tracked")
	`MSRHL_ASSERT_NEXT(a_under_only, !do_under, $stable(under_q), "underrun count moved")

endmodule
